// ===== sv/round_robin_dma_slot_allocator_core_defines.svh =====
// Assertion macros for the round robin DMA slot allocator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef ROUND_ROBIN_DMA_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define ROUND_ROBIN_DMA_SLOT_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

`define RRDSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define RRDSA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`else

`define RRDSA_ASSERT(lbl, prop)

`define RRDSA_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

// ===== sv/rrdsa_pkg.sv =====
// Shared types and constants of the round robin DMA slot allocator.
// No dependencies.
package rrdsa_pkg;

  localparam int unsigned SLOTS_DEF      = 32;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned SLOT_FIELD_MAX = 32;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              granted;
  } rsp_t;

  // Update command from the sequencer to the slot map.
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] idx;
  } map_cmd_t;

endpackage

// ===== sv/round_robin_dma_slot_allocator_core.sv =====
// Top level of the round robin DMA slot allocator: command port, scan sequencer.
// Depends on rrdsa_pkg, rrdsa_slot_map and the assertion macro header.

// Hands out DMA buffer slots from a busy bitmap in round robin order. Raise
// start with an item on req_i while busy is low; the item is taken at that
// edge. A release clears the named slot's busy bit and reports granted, or
// reports not granted when the index is not below the slot count; its result
// appears in the cycle after the item is taken and busy stays low, so a new
// item may follow at once. An allocate probes one slot per cycle through a
// single bit test, starting just after the last granted slot and wrapping at
// the slot count. It holds busy high while it probes (1 slot up to the slot
// count) and shows its result in the cycle after the last probe; a full map
// probes every slot and answers not granted with granted_slot zero, leaving
// state untouched. Every result stands on rsp_o for exactly one cycle under
// done_o; the receiver cannot stall it, so capture it in that cycle. SLOTS
// above 32 serves 32 slots.
`include "round_robin_dma_slot_allocator_core_defines.svh"

module round_robin_dma_slot_allocator_core #(
  parameter int unsigned SLOTS = rrdsa_pkg::SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rrdsa_pkg::req_t req_i,
  output logic            done_o,
  output rrdsa_pkg::rsp_t rsp_o
);
  import rrdsa_pkg::*;

  // Effective slot count: at least 2, clamped to the range the slot field can address.
  localparam int unsigned N =
    (SLOTS > SLOT_FIELD_MAX) ? SLOT_FIELD_MAX : ((SLOTS < 2) ? 2 : SLOTS);
  localparam int unsigned CNT_W = $clog2(N);

  localparam logic [SLOT_W:0]   NUM_SLOTS = (SLOT_W + 1)'(N);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(N - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(N - 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  map_cmd_t          map_cmd;
  logic              cand_busy;
  logic [SLOT_W-1:0] last_grant;
  logic              accept;

  rrdsa_slot_map #(
    .N (N)
  ) u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (map_cmd),
    .rd_idx_i     (cand_q),
    .rd_busy_o    (cand_busy),
    .last_grant_o (last_grant)
  );

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cand_d  = cand_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rsp_d   = '0;
    map_cmd = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.op == OP_RELEASE) begin
            // Clear, never toggle; drop indexes at or beyond the slot count.
            if ({1'b0, req_i.release_slot} < NUM_SLOTS) begin
              map_cmd.clr   = 1'b1;
              map_cmd.idx   = req_i.release_slot;
              rsp_d.granted = 1'b1;
            end
            done_d = 1'b1;
          end else begin
            // Start just after the last grant, wrapping at the last slot.
            cand_d  = (last_grant >= LAST_SLOT) ? '0 : last_grant + SLOT_W'(1);
            cnt_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!cand_busy) begin
          // Take the free slot and record it as the last grant.
          map_cmd.set        = 1'b1;
          map_cmd.idx        = cand_q;
          rsp_d.granted      = 1'b1;
          rsp_d.granted_slot = cand_q;
          done_d             = 1'b1;
          state_d            = S_IDLE;
        end else if (cnt_q == LAST_CNT) begin
          // Every slot probed busy: answer not granted, keep state.
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cand_d = (cand_q == LAST_SLOT) ? '0 : cand_q + SLOT_W'(1);
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cand_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  assign busy   = (state_q == S_SCAN);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A taken item either starts a scan or reports in the next cycle.
  `RRDSA_ASSERT_MSG(a_accept_progress, accept |=> (busy || done_o), "item not handled")
  // A result always closes the work, so the port is free again.
  `RRDSA_ASSERT_MSG(a_done_idle, done_o |-> !busy, "result shown while still scanning")
  // A granted slot lies inside the served range.
  `RRDSA_ASSERT(a_slot_range, done_o |-> ({1'b0, rsp_o.granted_slot} < NUM_SLOTS))
  // A refusal carries slot zero.
  `RRDSA_ASSERT(a_refuse_zero, (done_o && !rsp_o.granted) |-> (rsp_o.granted_slot == '0))

endmodule

// ===== sv/rrdsa_slot_map.sv =====
// Busy bitmap and last grant register of the slot allocator.
// Depends on rrdsa_pkg.
module rrdsa_slot_map #(
  parameter int unsigned N = rrdsa_pkg::SLOT_FIELD_MAX
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrdsa_pkg::map_cmd_t          cmd_i,
  input  logic [rrdsa_pkg::SLOT_W-1:0] rd_idx_i,
  output logic                         rd_busy_o,
  output logic [rrdsa_pkg::SLOT_W-1:0] last_grant_o
);
  import rrdsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(N);

  logic [N-1:0]      busy_map_q, busy_map_d;
  logic [SLOT_W-1:0] last_grant_q, last_grant_d;

  always_comb begin
    busy_map_d   = busy_map_q;
    last_grant_d = last_grant_q;
    if (cmd_i.set) begin
      busy_map_d[cmd_i.idx[IDX_W-1:0]] = 1'b1;
      last_grant_d                     = cmd_i.idx;
    end else if (cmd_i.clr) begin
      busy_map_d[cmd_i.idx[IDX_W-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_map_q   <= '0;
      last_grant_q <= SLOT_W'(N - 1);
    end else begin
      busy_map_q   <= busy_map_d;
      last_grant_q <= last_grant_d;
    end
  end

  assign rd_busy_o    = busy_map_q[rd_idx_i[IDX_W-1:0]];
  assign last_grant_o = last_grant_q;

endmodule

// ===== dv/tb_round_robin_dma_slot_allocator_core.sv =====
// Self-checking testbench for round_robin_dma_slot_allocator_core.
// Depends on rrdsa_pkg and the block; predicts every result and compares it
// field by field.
module tb_round_robin_dma_slot_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rrdsa_pkg::*;

  // Slots actually served: the slot fields are 5 bits, so saturate at 32.
  localparam int unsigned SLOT_N = (SLOTS_DEF > SLOT_FIELD_MAX) ? SLOT_FIELD_MAX :
                                   (SLOTS_DEF < 2) ? 2 : SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned BURST_LEN    = 30;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOT_N + 8;

  typedef struct {
    req_t        req;
    int unsigned idle_pct;
  } pending_item_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  // Stimulus waiting for the driver and grants waiting for the block.
  pending_item_t pending_q[$];
  rsp_t          grant_q[$];

  // Shadow copy of the slot map.
  logic [31:0]       slot_busy    = '0;
  logic [SLOT_W-1:0] last_granted = SLOT_W'(SLOT_N - 1);

  logic        item_taken = 1'b0;
  int unsigned err_count  = 0;

  round_robin_dma_slot_allocator_core #(
    .SLOTS(SLOTS_DEF)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_item(input logic op, input logic [SLOT_W-1:0] slot,
                          input int unsigned idle_pct);
    pending_item_t it;
    it.req.op           = op;
    it.req.release_slot = slot;
    it.idle_pct         = idle_pct;
    pending_q.push_back(it);
  endtask

  // Apply one request to the shadow map and return the grant it must produce.
  function automatic rsp_t predict_slot_grant(input req_t r);
    rsp_t        res;
    int unsigned first;
    int unsigned cand;
    int unsigned k;
    logic        found;
    res   = '0;
    found = 1'b0;
    if (r.op == OP_RELEASE) begin
      // Clear, never toggle; an index at or past the slot count is refused.
      if (r.release_slot < SLOT_N) begin
        slot_busy[r.release_slot] = 1'b0;
        res.granted = 1'b1;
      end
    end else begin
      // Search round robin from just after the last grant, wrapping at SLOT_N.
      first = (last_granted >= SLOT_N - 1) ? 0 : last_granted + 1;
      for (k = 0; k < SLOT_N; k++) begin
        cand = first + k;
        if (cand >= SLOT_N) cand -= SLOT_N;
        if (!found && !slot_busy[cand]) begin
          found             = 1'b1;
          slot_busy[cand]   = 1'b1;
          last_granted      = cand[SLOT_W-1:0];
          res.granted_slot  = cand[SLOT_W-1:0];
          res.granted       = 1'b1;
        end
      end
      // A full map leaves everything untouched and answers not granted.
    end
    return res;
  endfunction

  // Driver: present items at the falling edge; hold start and the item until
  // the block takes it, then move on or idle per the item's idle chance.
  always @(negedge clk_i) begin
    pending_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold the current item
    end else if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
      nxt = pending_q.pop_front();
      start <= 1'b1;
      req_i <= nxt.req;
    end else begin
      // idle: scramble the payload, which must be ignored while start is low
      start <= 1'b0;
      req_i <= req_t'($urandom);
    end
  end

  // Monitor: check grants first, then record a newly taken item. A result
  // never belongs to an item taken at the same edge, so this order is safe.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result slot=%0d granted=%0b",
                                    rsp_o.granted_slot, rsp_o.granted));
        end else begin
          want = grant_q.pop_front();
          if (rsp_o.granted_slot !== want.granted_slot)
            report_mismatch($sformatf("granted_slot %0d, want %0d",
                                      rsp_o.granted_slot, want.granted_slot));
          if (rsp_o.granted !== want.granted)
            report_mismatch($sformatf("granted %0b, want %0b",
                                      rsp_o.granted, want.granted));
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) grant_q.push_back(predict_slot_grant(req_i));
    end else begin
      item_taken <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned idle_by_phase[4];
    int unsigned alloc_pct;
    int unsigned phase;
    int unsigned n;

    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;

    // Directed: first grant is slot 0, then release a busy slot, release a
    // free slot (stays clear, still granted), the top and bottom indexes,
    // and a search that must skip past the freed slot.
    add_item(OP_ALLOC, 5'd0, 0);
    add_item(OP_ALLOC, 5'd31, 0);
    add_item(OP_ALLOC, 5'd17, 0);
    add_item(OP_RELEASE, 5'd1, 0);
    add_item(OP_RELEASE, 5'd1, 0);
    add_item(OP_RELEASE, 5'd31, 0);
    add_item(OP_ALLOC, 5'd0, 0);
    add_item(OP_RELEASE, 5'd0, 0);
    add_item(OP_ALLOC, 5'd0, 0);
    add_item(OP_RELEASE, 5'd21, 0);
    add_item(OP_RELEASE, 5'd10, 0);
    add_item(OP_ALLOC, 5'd31, 0);

    // Random: bursts that lean toward allocation drive the map full (and the
    // search through the wrap), bursts that lean toward release drain it.
    idle_by_phase = '{0, 65, 0, 23};
    alloc_pct     = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n * 4 / RANDOM_ITEMS;
      if (n % BURST_LEN == 0) begin
        case ($urandom_range(2))
          0: alloc_pct = 92;
          1: alloc_pct = 15;
          default: alloc_pct = 55;
        endcase
      end
      add_item(($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_RELEASE,
               SLOT_W'($urandom_range(31)), idle_by_phase[phase]);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every item taken, every grant seen, then let the block settle.
    wait (pending_q.size() == 0 && !start);
    wait (grant_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (grant_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grant_q.size()));

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
